@@ hdl/afq_pkg.sv @@
// Shared types, constants and helpers for the audio frame queue DAC playout block.
package afq_pkg;

  localparam int FRAME_SAMPLES = 2048;
  localparam int QUEUE_FRAMES  = 4;

  localparam int SLOT_W = $clog2(QUEUE_FRAMES);
  localparam int OFS_W  = $clog2(FRAME_SAMPLES + 1);
  localparam int ADDR_W = $clog2(FRAME_SAMPLES * QUEUE_FRAMES);
  localparam int DAC_W  = 12;
  localparam int VOL_W  = 5;

  localparam logic [VOL_W-1:0] VOL_MIN   = VOL_W'(1);
  localparam logic [VOL_W-1:0] VOL_MAX   = VOL_W'(19);
  localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(14);

  // Request kinds
  localparam logic [2:0] KIND_PUSH   = 3'd0;
  localparam logic [2:0] KIND_TICK   = 3'd1;
  localparam logic [2:0] KIND_STOP   = 3'd2;
  localparam logic [2:0] KIND_PAUSE  = 3'd3;
  localparam logic [2:0] KIND_RESUME = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_BUSY = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               stereo;
    logic               last_of_frame;
    logic [31:0]        frame_number;
  } in_t;

  typedef struct packed {
    logic [DAC_W-1:0] dac_value;
    logic             dac_valid;
    logic [1:0]       status;
    logic [31:0]      current_frame;
    logic             queue_free;
    logic             queue_empty;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DONE = 2'b10
  } fsm_t;

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    slot_next = (s == SLOT_W'(QUEUE_FRAMES - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [OFS_W-1:0]  o);
    store_addr = ADDR_W'(s) * ADDR_W'(FRAME_SAMPLES) + ADDR_W'(o);
  endfunction

endpackage

@@ hdl/afq_conv.sv @@
// Sample converter: 16-bit signed to 12-bit offset binary; stereo is downmixed and volume-scaled, mono passes through.
module afq_conv (
  input  logic signed [15:0]              left_sample,
  input  logic signed [15:0]              right_sample,
  input  logic                            stereo,
  input  logic [afq_pkg::VOL_W-1:0]       volume,
  output logic [afq_pkg::DAC_W-1:0]       dac_value
);

  logic [afq_pkg::DAC_W-1:0] u_l;
  logic [afq_pkg::DAC_W-1:0] u_r;
  logic [afq_pkg::VOL_W-1:0] vol_c;
  logic [afq_pkg::VOL_W-1:0] atten;
  logic [afq_pkg::DAC_W-1:0] mix;
  logic [afq_pkg::DAC_W-1:0] shifted;
  logic [afq_pkg::DAC_W-1:0] scaled;

  // Flip the sign bit for offset binary, keep the top 12 bits
  assign u_l = {~left_sample[15], left_sample[14:4]};
  assign u_r = {~right_sample[15], right_sample[14:4]};

  always_comb begin
    if (volume < afq_pkg::VOL_MIN) begin
      vol_c = afq_pkg::VOL_MIN;
    end else if (volume > afq_pkg::VOL_MAX) begin
      vol_c = afq_pkg::VOL_MAX;
    end else begin
      vol_c = volume;
    end
  end

  assign atten   = afq_pkg::VOL_MAX - vol_c;
  assign mix     = (u_l >> 1) + (u_r >> 1);
  assign shifted = mix >> atten[afq_pkg::VOL_W-1:1];
  // Roughly 0.703: 1/2 + 1/8 + 1/16 + 1/64
  assign scaled  = (shifted >> 1) + (shifted >> 3) + (shifted >> 4) + (shifted >> 6);

  always_comb begin
    if (!stereo) begin
      dac_value = u_l;
    end else if (atten[0]) begin
      dac_value = scaled;
    end else begin
      dac_value = shifted;
    end
  end

endmodule

@@ hdl/audio_frame_queue_dac_playout.sv @@
// Top level: audio frame ring with sample store, playback control and DAC output register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | request   | in_valid/in_stall  | afq_pkg::in_t (push/tick/stop/...)
//  out_    | result    | out_valid/out_stall| afq_pkg::out_t (DAC sample, status)
//  cfg_    | write     | cfg_valid/cfg_ready| volume_level, 5 bits
//
// Each request passes through the accept cycle, which updates the slot state and
// reads or writes the single-port sample store, and the ST_DONE state, which folds
// the registered read data into the result register once the output register
// is empty or being drained. Synchronous reset frees all slots, stops playback and
// sets the volume to 14; the sample store is not cleared. A stalled result
// holds in the output register; the block takes the next request meanwhile and
// holds its result until the register frees.
module audio_frame_queue_dac_playout (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  afq_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output afq_pkg::out_t             out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [afq_pkg::VOL_W-1:0] cfg_data
);

  // Sample store: one access per cycle, registered read data
  logic [afq_pkg::DAC_W-1:0] store_mem [afq_pkg::FRAME_SAMPLES * afq_pkg::QUEUE_FRAMES];
  logic [afq_pkg::DAC_W-1:0] rd_data_r;
  logic                      mem_we;
  logic                      mem_re;
  logic [afq_pkg::ADDR_W-1:0] mem_addr;
  logic [afq_pkg::DAC_W-1:0] conv_value;

  // Ring control state
  logic [afq_pkg::OFS_W-1:0]  slot_len_r   [afq_pkg::QUEUE_FRAMES];
  logic [afq_pkg::OFS_W-1:0]  slot_len_nxt [afq_pkg::QUEUE_FRAMES];
  logic [31:0]                slot_frame_r   [afq_pkg::QUEUE_FRAMES];
  logic [31:0]                slot_frame_nxt [afq_pkg::QUEUE_FRAMES];
  logic [afq_pkg::SLOT_W-1:0] prod_r, prod_nxt;
  logic [afq_pkg::SLOT_W-1:0] cons_r, cons_nxt;
  logic [afq_pkg::OFS_W-1:0]  wr_ofs_r, wr_ofs_nxt;
  logic [afq_pkg::OFS_W-1:0]  rd_ofs_r, rd_ofs_nxt;
  logic                       playing_r, playing_nxt;
  logic [afq_pkg::VOL_W-1:0]  volume_r;

  // Per-request result fields, carried to the result cycle
  logic                       tick_valid_r, tick_valid_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic [2:0]                 kind_r;

  afq_pkg::fsm_t              state_r, state_nxt;
  logic                       out_valid_r;
  afq_pkg::out_t              out_data_r;
  logic                       in_acc;
  logic                       out_load;

  assign in_stall  = (state_r != afq_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  // Load the result once the output register is empty or being drained
  assign out_load  = (state_r == afq_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  afq_conv u_conv (
    .left_sample  (in_data.left_sample),
    .right_sample (in_data.right_sample),
    .stereo       (in_data.stereo),
    .volume       (volume_r),
    .dac_value    (conv_value)
  );

  // Request decode: update ring state, drive the store access
  always_comb begin
    logic [afq_pkg::OFS_W-1:0]  wo_new;
    logic [afq_pkg::OFS_W-1:0]  ro;
    logic [afq_pkg::SLOT_W-1:0] c_next;

    slot_len_nxt   = slot_len_r;
    slot_frame_nxt = slot_frame_r;
    prod_nxt       = prod_r;
    cons_nxt       = cons_r;
    wr_ofs_nxt     = wr_ofs_r;
    rd_ofs_nxt     = rd_ofs_r;
    playing_nxt    = playing_r;
    tick_valid_nxt = 1'b0;
    status_nxt     = afq_pkg::STAT_OK;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = '0;
    wo_new         = wr_ofs_r;
    ro             = '0;
    c_next         = afq_pkg::slot_next(cons_r);

    if (in_acc) begin
      case (in_data.kind)
        afq_pkg::KIND_PUSH: begin
          if (slot_len_r[prod_r] != '0) begin
            // Reject: slot still holds an unplayed frame
            status_nxt = afq_pkg::STAT_BUSY;
          end else begin
            if (wr_ofs_r >= afq_pkg::OFS_W'(afq_pkg::FRAME_SAMPLES)) begin
              status_nxt = afq_pkg::STAT_FULL;
            end else begin
              mem_we   = 1'b1;
              mem_addr = afq_pkg::store_addr(prod_r, wr_ofs_r);
              wo_new   = wr_ofs_r + afq_pkg::OFS_W'(1);
            end
            if (in_data.last_of_frame) begin
              // Commit the frame and (re)start playback
              slot_len_nxt[prod_r]   = wo_new;
              slot_frame_nxt[prod_r] = in_data.frame_number;
              prod_nxt               = afq_pkg::slot_next(prod_r);
              wr_ofs_nxt             = '0;
              playing_nxt            = 1'b1;
            end else begin
              wr_ofs_nxt = wo_new;
            end
          end
        end
        afq_pkg::KIND_TICK: begin
          if (playing_r) begin
            if (slot_len_r[cons_r] == '0) begin
              playing_nxt = 1'b0;
            end else begin
              ro = (rd_ofs_r >= afq_pkg::OFS_W'(afq_pkg::FRAME_SAMPLES)) ? '0 : rd_ofs_r;
              mem_re         = 1'b1;
              mem_addr       = afq_pkg::store_addr(cons_r, ro);
              tick_valid_nxt = 1'b1;
              ro             = ro + afq_pkg::OFS_W'(1);
              if (ro >= slot_len_r[cons_r]) begin
                // End of frame: free the slot, advance, stop on an empty ring
                slot_len_nxt[cons_r] = '0;
                rd_ofs_nxt           = '0;
                cons_nxt             = c_next;
                if (slot_len_r[c_next] == '0) begin
                  playing_nxt = 1'b0;
                end
              end else begin
                rd_ofs_nxt = ro;
              end
            end
          end
        end
        afq_pkg::KIND_STOP: begin
          for (int i = 0; i < afq_pkg::QUEUE_FRAMES; i++) begin
            slot_len_nxt[i] = '0;
          end
          prod_nxt    = '0;
          cons_nxt    = '0;
          wr_ofs_nxt  = '0;
          rd_ofs_nxt  = '0;
          playing_nxt = 1'b0;
        end
        afq_pkg::KIND_PAUSE: begin
          playing_nxt = 1'b0;
        end
        afq_pkg::KIND_RESUME: begin
          playing_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      afq_pkg::ST_IDLE: if (in_acc) state_nxt = afq_pkg::ST_DONE;
      afq_pkg::ST_DONE: if (out_load) state_nxt = afq_pkg::ST_IDLE;
      default:          state_nxt = afq_pkg::ST_IDLE;
    endcase
  end

  // Sample store: no reset, entries are written before they are ever read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_addr] <= conv_value;
    end
    if (mem_re) begin
      rd_data_r <= store_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < afq_pkg::QUEUE_FRAMES; i++) begin
        slot_len_r[i]   <= '0;
        slot_frame_r[i] <= '0;
      end
      prod_r       <= '0;
      cons_r       <= '0;
      wr_ofs_r     <= '0;
      rd_ofs_r     <= '0;
      playing_r    <= 1'b0;
      volume_r     <= afq_pkg::VOL_RESET;
      state_r      <= afq_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      tick_valid_r <= 1'b0;
      status_r     <= afq_pkg::STAT_OK;
      kind_r       <= afq_pkg::KIND_PUSH;
    end else begin
      slot_len_r   <= slot_len_nxt;
      slot_frame_r <= slot_frame_nxt;
      prod_r       <= prod_nxt;
      cons_r       <= cons_nxt;
      wr_ofs_r     <= wr_ofs_nxt;
      rd_ofs_r     <= rd_ofs_nxt;
      playing_r    <= playing_nxt;
      state_r      <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        volume_r <= cfg_data;
      end
      if (in_acc) begin
        tick_valid_r <= tick_valid_nxt;
        status_r     <= status_nxt;
        kind_r       <= in_data.kind;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: ring status is sampled after the request took effect
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.dac_value     <= tick_valid_r ? rd_data_r : '0;
      out_data_r.dac_valid     <= tick_valid_r;
      out_data_r.status        <= status_r;
      out_data_r.current_frame <= slot_frame_r[cons_r];
      out_data_r.queue_free    <= (slot_len_r[prod_r] == '0);
      out_data_r.queue_empty   <= (slot_len_r[cons_r] == '0);
    end
  end

  // Every accepted request is followed by its result cycle
  a_acc_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == afq_pkg::ST_DONE))
    else $error("accepted request did not enter result cycle");

  // A commit into a free slot always leaves playback running
  a_commit_plays: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.kind == afq_pkg::KIND_PUSH && in_data.last_of_frame
     && slot_len_r[prod_r] == '0) |=> playing_r)
    else $error("frame commit did not start playback");

  // Offsets stay within a frame
  a_ofs_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ofs_r <= afq_pkg::OFS_W'(afq_pkg::FRAME_SAMPLES))
    && (rd_ofs_r < afq_pkg::OFS_W'(afq_pkg::FRAME_SAMPLES)))
    else $error("frame offset out of range");

  // Only pushes report a nonzero status, only ticks produce a sample
  a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == afq_pkg::ST_DONE) |->
      ((status_r == afq_pkg::STAT_OK || kind_r == afq_pkg::KIND_PUSH)
       && (!tick_valid_r || kind_r == afq_pkg::KIND_TICK)))
    else $error("result fields do not match request kind");

endmodule

@@ tb/tb_audio_frame_queue_dac_playout.sv @@
// Self-checking testbench for the audio frame ring that feeds a 12-bit DAC.
module tb_audio_frame_queue_dac_playout;
  timeunit 1ns;
  timeprecision 1ps;

  // Kinds that the block must ignore.
  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

  localparam int STORE_DEPTH    = afq_pkg::FRAME_SAMPLES * afq_pkg::QUEUE_FRAMES;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 20;    // margin for the pipeline to show any stray result
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
  localparam int MAX_REPORTS    = 30;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  afq_pkg::in_t              in_data   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  afq_pkg::out_t             out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [afq_pkg::VOL_W-1:0] cfg_data  = afq_pkg::VOL_RESET;

  // Playout model state: sample ring, per-slot length and tag, both cursors.
  logic [afq_pkg::DAC_W-1:0] pcm_store [STORE_DEPTH];
  int                        frame_len [afq_pkg::QUEUE_FRAMES];
  logic [31:0]               frame_tag [afq_pkg::QUEUE_FRAMES];
  int                        prod_slot;
  int                        cons_slot;
  int                        wr_ofs;
  int                        rd_ofs;
  bit                        playing_now;
  logic [afq_pkg::VOL_W-1:0] volume_now;

  // Results owed by the block, oldest first.
  afq_pkg::out_t awaited_results [$];

  int sent_count    = 0;
  int checked_count = 0;
  int error_count   = 0;
  int cfg_count     = 0;
  int idle_cycles   = 0;
  int gap_pct       = 9;  // chance in percent that the sender idles a cycle
  int stall_pct     = 9;  // chance in percent that the receiver stalls a cycle

  audio_frame_queue_dac_playout dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Playout model
  // ---------------------------------------------------------------------------

  // Flip the sign bit to get offset binary, keep the top 12 bits.
  function automatic int offset12(logic signed [15:0] s);
    return int'({~s[15], s[14:4]});
  endfunction

  // Mono passes straight through. Stereo averages the channels, then halves
  // per two volume steps below the top, with a ~0.703 scale on odd steps.
  function automatic logic [afq_pkg::DAC_W-1:0] dac_code(afq_pkg::in_t r,
                                                         logic [afq_pkg::VOL_W-1:0] vol);
    int v;
    int atten;
    int t;
    if (!r.stereo) return afq_pkg::DAC_W'(offset12(r.left_sample));
    v = int'(vol);
    if (v < int'(afq_pkg::VOL_MIN)) v = int'(afq_pkg::VOL_MIN);
    if (v > int'(afq_pkg::VOL_MAX)) v = int'(afq_pkg::VOL_MAX);
    atten = int'(afq_pkg::VOL_MAX) - v;
    t = (offset12(r.left_sample) >> 1) + (offset12(r.right_sample) >> 1);
    t = t >> (atten >> 1);
    if (atten % 2 == 1) t = (t >> 1) + (t >> 3) + (t >> 4) + (t >> 6);
    return afq_pkg::DAC_W'(t);
  endfunction

  // Free every slot and rewind both cursors; frame tags survive.
  function automatic void clear_ring();
    foreach (frame_len[i]) frame_len[i] = 0;
    prod_slot   = 0;
    cons_slot   = 0;
    wr_ofs      = 0;
    rd_ofs      = 0;
    playing_now = 1'b0;
  endfunction

  // Apply one request to the model and return the result it owes.
  function automatic afq_pkg::out_t predict_playout(afq_pkg::in_t r);
    afq_pkg::out_t o;
    o = '0;
    o.status = afq_pkg::STAT_OK;
    case (r.kind)
      afq_pkg::KIND_PUSH: begin
        if (frame_len[prod_slot] != 0) begin
          o.status = afq_pkg::STAT_BUSY;
        end else begin
          if (wr_ofs >= afq_pkg::FRAME_SAMPLES) begin
            o.status = afq_pkg::STAT_FULL;
          end else begin
            pcm_store[prod_slot * afq_pkg::FRAME_SAMPLES + wr_ofs] = dac_code(r, volume_now);
            wr_ofs++;
          end
          if (r.last_of_frame) begin
            frame_len[prod_slot] = wr_ofs;
            frame_tag[prod_slot] = r.frame_number;
            prod_slot = (prod_slot + 1) % afq_pkg::QUEUE_FRAMES;
            wr_ofs = 0;
            playing_now = 1'b1;
          end
        end
      end
      afq_pkg::KIND_TICK: begin
        if (playing_now) begin
          if (frame_len[cons_slot] == 0) begin
            playing_now = 1'b0;
          end else begin
            if (rd_ofs >= afq_pkg::FRAME_SAMPLES) rd_ofs = 0;
            o.dac_value = pcm_store[cons_slot * afq_pkg::FRAME_SAMPLES + rd_ofs];
            o.dac_valid = 1'b1;
            rd_ofs++;
            if (rd_ofs >= frame_len[cons_slot]) begin
              frame_len[cons_slot] = 0;
              rd_ofs = 0;
              cons_slot = (cons_slot + 1) % afq_pkg::QUEUE_FRAMES;
              if (frame_len[cons_slot] == 0) playing_now = 1'b0;
            end
          end
        end
      end
      afq_pkg::KIND_STOP:   clear_ring();
      afq_pkg::KIND_PAUSE:  playing_now = 1'b0;
      afq_pkg::KIND_RESUME: playing_now = 1'b1;
      default: ;
    endcase
    o.current_frame = frame_tag[cons_slot];
    o.queue_free    = (frame_len[prod_slot] == 0);
    o.queue_empty   = (frame_len[cons_slot] == 0);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------

  // Lean toward the extremes now and then.
  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic afq_pkg::in_t push_req(logic signed [15:0] l, logic signed [15:0] r,
                                            bit stereo, bit last, logic [31:0] tag);
    afq_pkg::in_t q;
    q               = '0;
    q.kind          = afq_pkg::KIND_PUSH;
    q.left_sample   = l;
    q.right_sample  = r;
    q.stereo        = stereo;
    q.last_of_frame = last;
    q.frame_number  = tag;
    return q;
  endfunction

  // Non-push kinds carry random payload: the block must ignore it.
  function automatic afq_pkg::in_t ctrl_req(logic [2:0] k);
    afq_pkg::in_t q;
    q               = '0;
    q.kind          = k;
    q.left_sample   = 16'($urandom);
    q.right_sample  = 16'($urandom);
    q.stereo        = 1'($urandom);
    q.last_of_frame = 1'($urandom);
    q.frame_number  = $urandom;
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Send one request. Call right after a rising edge; return at the edge that
  // accepted it, so the next request can follow back to back.
  task automatic issue_request(afq_pkg::in_t r);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    awaited_results.push_back(predict_playout(r));
    sent_count++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) issue_request(ctrl_req(afq_pkg::KIND_TICK));
  endtask

  // Hold the sender until every owed result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // Write the volume register once the block is idle.
  task automatic set_volume(logic [afq_pkg::VOL_W-1:0] v);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    volume_now  = v;
    cfg_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    afq_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        checked_count++;
        if (awaited_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          want = awaited_results.pop_front();
          check_field("dac_value",     want.dac_value,     out_data.dac_value);
          check_field("dac_valid",     want.dac_valid,     out_data.dac_valid);
          check_field("status",        want.status,        out_data.status);
          check_field("current_frame", want.current_frame, out_data.current_frame);
          check_field("queue_free",    want.queue_free,    out_data.queue_free);
          check_field("queue_empty",   want.queue_empty,   out_data.queue_empty);
        end
      end
      // Stall the result channel at random; never when stall_pct is zero.
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Abort when no channel has moved for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, awaited_results.size());
        $display("tb_audio_frame_queue_dac_playout NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Conversion extremes at the reset volume, ticks while stopped, resume on an
  // empty ring, frame tag extremes and the ignored kinds.
  task automatic test_directed_extremes();
    issue_request(ctrl_req(afq_pkg::KIND_TICK));    // stopped: nothing plays
    issue_request(ctrl_req(afq_pkg::KIND_RESUME));  // playing with an empty ring
    issue_request(ctrl_req(afq_pkg::KIND_TICK));    // stops again
    issue_request(ctrl_req(afq_pkg::KIND_PAUSE));
    // Mono frame, tag zero: no volume applied.
    issue_request(push_req(16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 32'h0));
    issue_request(push_req(16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 32'h0));
    issue_request(push_req(16'sh0000, 16'sh0000, 1'b0, 1'b0, 32'h0));
    issue_request(push_req(-16'sd1,   -16'sd1,   1'b0, 1'b1, 32'h0));
    // Stereo frame, tag all ones: reset volume attenuates.
    issue_request(push_req(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, 32'hFFFF_FFFF));
    issue_request(push_req(16'sh8000, 16'sh8000, 1'b1, 1'b0, 32'hFFFF_FFFF));
    issue_request(push_req(16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_ticks(8);                         // seven samples, then the ring runs dry
    for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
      issue_request(ctrl_req(3'(k)));
    issue_request(ctrl_req(afq_pkg::KIND_STOP));
  endtask

  // Fill the ring, bounce pushes off a busy slot, gate playback with pause and
  // resume, and drop pending frames with stop.
  task automatic test_ring_control();
    issue_request(ctrl_req(afq_pkg::KIND_STOP));
    issue_request(ctrl_req(afq_pkg::KIND_PAUSE));
    // Each commit restarts playback even though paused.
    for (int s = 0; s < afq_pkg::QUEUE_FRAMES; s++)
      issue_request(push_req(rand_sample(), rand_sample(), 1'($urandom), 1'b1, $urandom));
    issue_request(push_req(rand_sample(), rand_sample(), 1'b1, 1'b0, $urandom)); // busy
    issue_request(push_req(rand_sample(), rand_sample(), 1'b0, 1'b1, $urandom)); // busy
    issue_request(ctrl_req(afq_pkg::KIND_PAUSE));
    issue_request(ctrl_req(afq_pkg::KIND_TICK));    // paused: nothing plays
    issue_request(ctrl_req(afq_pkg::KIND_RESUME));
    send_ticks(2);                         // frees the first two slots
    for (int i = 0; i < 3; i++)
      issue_request(push_req(rand_sample(), rand_sample(), 1'($urandom), i == 2, $urandom));
    send_ticks(3);                         // two old frames, first sample of the new one
    issue_request(ctrl_req(afq_pkg::KIND_PAUSE));   // pause mid-frame
    issue_request(ctrl_req(afq_pkg::KIND_TICK));
    issue_request(ctrl_req(afq_pkg::KIND_RESUME));
    send_ticks(3);                         // finish the frame, then run dry
    // Stop with a half-written frame, then with a committed one.
    issue_request(push_req(rand_sample(), rand_sample(), 1'b1, 1'b0, $urandom));
    issue_request(push_req(rand_sample(), rand_sample(), 1'b0, 1'b0, $urandom));
    issue_request(ctrl_req(afq_pkg::KIND_STOP));
    issue_request(ctrl_req(afq_pkg::KIND_TICK));
    issue_request(push_req(rand_sample(), rand_sample(), 1'b1, 1'b0, $urandom));
    issue_request(push_req(rand_sample(), rand_sample(), 1'b1, 1'b1, $urandom));
    issue_request(ctrl_req(afq_pkg::KIND_STOP));
    issue_request(ctrl_req(afq_pkg::KIND_TICK));
    issue_request(ctrl_req(afq_pkg::KIND_RESUME));
    issue_request(ctrl_req(afq_pkg::KIND_TICK));    // empty slot: playback stops
  endtask

  // Walk every value the register can hold, out-of-range ones included, and
  // play a short mixed frame at each.
  task automatic test_volume_sweep();
    for (int v = 0; v < (1 << afq_pkg::VOL_W); v++) begin
      set_volume(afq_pkg::VOL_W'(v));
      issue_request(push_req(rand_sample(), rand_sample(), 1'b1, 1'b0, $urandom));
      issue_request(push_req(rand_sample(), rand_sample(), 1'b0, 1'b0, $urandom));
      issue_request(push_req(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, $urandom));
      send_ticks(4);
    end
  endtask

  // Mostly well-formed frames of random length and content interleaved with
  // ticks, plus pause, resume, stop, ignored kinds and raw noise. Each phase
  // runs at its own volume; one phase runs with no idling on either side.
  task automatic test_random_traffic();
    logic [afq_pkg::VOL_W-1:0] phase_vol [6];
    int                        frame_left;
    int                        pick;
    afq_pkg::in_t              noise;
    phase_vol[0] = afq_pkg::VOL_MIN;
    phase_vol[1] = afq_pkg::VOL_MAX;
    phase_vol[2] = afq_pkg::VOL_W'($urandom_range(afq_pkg::VOL_MIN, afq_pkg::VOL_MAX));
    phase_vol[3] = '0;
    phase_vol[4] = '1;
    phase_vol[5] = afq_pkg::VOL_W'($urandom_range(afq_pkg::VOL_MIN, afq_pkg::VOL_MAX));
    frame_left = 0;
    for (int phase = 0; phase < 6; phase++) begin
      set_volume(phase_vol[phase]);
      gap_pct   = (phase == 2) ? 0 : 9;
      stall_pct = (phase == 2) ? 0 : 9;
      for (int i = 0; i < 110; i++) begin
        if (frame_left == 0)
          frame_left = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
        pick = $urandom_range(99);
        if (pick < 50) begin
          issue_request(push_req(rand_sample(), rand_sample(), 1'($urandom),
                                 frame_left == 1, $urandom));
          frame_left--;
        end else if (pick < 84) begin
          issue_request(ctrl_req(afq_pkg::KIND_TICK));
        end else if (pick < 87) begin
          issue_request(ctrl_req(afq_pkg::KIND_PAUSE));
        end else if (pick < 92) begin
          issue_request(ctrl_req(afq_pkg::KIND_RESUME));
        end else if (pick < 94) begin
          issue_request(ctrl_req(afq_pkg::KIND_STOP));
          frame_left = 0;
        end else if (pick < 97) begin
          issue_request(ctrl_req(3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST))));
        end else begin
          // Raw push with every field random: breaks the frame structure.
          noise = ctrl_req(afq_pkg::KIND_PUSH);
          noise.left_sample = rand_sample();
          issue_request(noise);
        end
      end
    end
    gap_pct   = 9;
    stall_pct = 9;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    foreach (frame_tag[i]) frame_tag[i] = '0;
    clear_ring();
    volume_now = afq_pkg::VOL_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_ring_control();
    test_volume_sweep();
    test_random_traffic();

    // Drain, then give the pipeline time to show any stray result.
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests, checked %0d results, %0d volume writes (0..31 swept).",
             sent_count, checked_count, cfg_count);
    $display("Covered conversion extremes, busy slots, pause, resume, stop and random frames.");
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("tb_audio_frame_queue_dac_playout OK");
    end else begin
      $display("tb_audio_frame_queue_dac_playout NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/afq_pkg.sv
hdl/afq_conv.sv
hdl/audio_frame_queue_dac_playout.sv
tb/tb_audio_frame_queue_dac_playout.sv
